// ----- rtl/core/emgtq_pkg.sv -----
package emgtq_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int TBL_N  = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_COEF_INPUT = 2'd0;
  localparam logic [1:0] CFG_COEF_PREV  = 2'd1;
  localparam logic [1:0] CFG_COEF_PREV2 = 2'd2;

  localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(64'sd1 <<< 29);
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(64'sd1 <<< 15);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // per-motor constants: reciprocal norms in Q2.30, active gain integer,
  // passive gain Q16.16
  localparam word_t RECIP_FLEX [TBL_N] = '{
    32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 32'sd2014147109,
    32'sd932553260,  32'sd932553260,  32'sd932553260,  32'sd932553260,
    32'sd932553260,  32'sd932553260,  32'sd932553260,  32'sd932553260,
    32'sd932553260,  32'sd932553260,  32'sd932553260,  32'sd932553260
  };

  localparam word_t RECIP_EXT [TBL_N] = '{
    32'sd1073741824, 32'sd1073741824, 32'sd1073741824, 32'sd1363654844,
    32'sd773923760,  32'sd773923760,  32'sd773923760,  32'sd773923760,
    32'sd773923760,  32'sd773923760,  32'sd773923760,  32'sd773923760,
    32'sd773923760,  32'sd773923760,  32'sd773923760,  32'sd773923760
  };

  localparam word_t GAIN_ACTIVE [TBL_N] = '{
    32'sd0,    32'sd0,    32'sd0,    32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500,
    32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500, 32'sd1500
  };

  localparam word_t GAIN_PASSIVE [TBL_N] = '{
    32'sd0,     32'sd0,     32'sd0,     32'sd0,
    32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768,
    32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768,
    32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768
  };

  // clamp a wide signed value to the signed 32-bit range
  function automatic word_t sat32(input acc_t v);
    acc_t hi_lim;
    acc_t lo_lim;
    hi_lim = ACC_W'(64'sd2147483647);
    lo_lim = -ACC_W'(64'sd2147483648);
    if (v > hi_lim) begin
      return word_t'(32'sh7fffffff);
    end else if (v < lo_lim) begin
      return word_t'(32'sh80000000);
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/emgtq_mul.sv -----
module emgtq_mul
  import emgtq_pkg::*;
(
  input  logic  clk,
  input  word_t op_a,
  input  word_t op_b,
  output prod_t prod_r
);

  // signed 32x32 multiply with the product registered
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ----- rtl/core/emg_torque_second_order_filter_top.sv -----
// emg activation to filtered reference position, one motor sample per transaction
//
// input channel: in_valid / in_stall with motor index, weighted activation and
// motor position (Q16.16). output channel: out_valid / out_stall with channel
// and saturated reference position (Q16.16). a transaction moves on an edge
// with valid high and stall low.
// configuration: cfg_we, cfg_index, cfg_wdata write the three Q2.30 filter
// coefficients; write them only while the block is idle, other indexes ignored.
//
// one 32x32 multiplier is shared by six products under a small sequencer: after
// the input transaction come six multiply steps, the last accumulate, rounding
// and the hand-over to the output register; out_valid rises on the same edge at
// which in_stall drops, and only then is a new item taken. a motor index out of
// range skips the multiply steps and returns zero without touching state.
// the output register frees the datapath: a new item is taken while a result
// waits; if the receiver still stalls when the next result is done, the block
// holds that result and keeps in_stall high until the output register empties.
// synchronous reset clears the coefficients, both filter histories and the
// output valid.
module emg_torque_second_order_filter_top
  import emgtq_pkg::*;
#(
  parameter int NUM_MOTORS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_motor_index,
  input  word_t       in_weighted_activation,
  input  word_t       in_motor_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_channel,
  output word_t       out_ref_position,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  word_t       cfg_wdata
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MUL_ACT = 10'b0000000010,
    S_MUL_PAS = 10'b0000000100,
    S_MUL_GN  = 10'b0000001000,
    S_DES     = 10'b0000010000,
    S_MUL_IN  = 10'b0000100000,
    S_MUL_OLD = 10'b0001000000,
    S_ACC3    = 10'b0010000000,
    S_FIN     = 10'b0100000000,
    S_WB      = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // coefficients
  word_t coef_input_r, coef_prev_r, coef_prev2_r;

  // filter history per motor
  word_t last_r  [NUM_MOTORS];
  word_t older_r [NUM_MOTORS];

  // captured transaction
  logic [3:0] m_r;
  word_t      act_r, pos_r;

  // datapath registers
  word_t      r_r;
  logic signed [DATA_W:0] tpas_r;
  word_t      tdes_r;
  acc_t       acc_r;
  word_t      y_r;

  // output register
  logic       out_valid_r;
  logic [3:0] out_channel_r;
  word_t      out_ref_r;

  // shared multiplier
  word_t op_a, op_b;
  prod_t prod_r;

  emgtq_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  logic [IDX_W-1:0] mi;
  logic             in_take;
  logic             m_bad;
  logic             out_free;

  assign mi       = m_r[IDX_W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && (state_r == S_IDLE);
  assign m_bad    = ({1'b0, in_motor_index} >= 5'(NUM_MOTORS));
  assign out_free = !out_valid_r || !out_stall;

  // rounded intermediate values and the torque difference
  prod_t r_round, tpas_round, t_diff;
  acc_t  y_round;

  always_comb begin
    r_round    = (prod_r + HALF30) >>> 30;
    tpas_round = (prod_r + HALF16) >>> 16;
    t_diff     = prod_r - PROD_W'(tpas_r);
    y_round    = (acc_r + ACC_W'(HALF30)) >>> 30;
  end

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_MUL_ACT: begin
        op_a = act_r;
        op_b = (act_r > 0) ? RECIP_FLEX[m_r] : RECIP_EXT[m_r];
      end
      S_MUL_PAS: begin
        op_a = GAIN_PASSIVE[m_r];
        op_b = pos_r;
      end
      S_MUL_GN: begin
        op_a = r_r;
        op_b = GAIN_ACTIVE[m_r];
      end
      S_DES: begin
        op_a = coef_prev_r;
        op_b = last_r[mi];
      end
      S_MUL_IN: begin
        op_a = coef_input_r;
        op_b = tdes_r;
      end
      S_MUL_OLD: begin
        op_a = coef_prev2_r;
        op_b = older_r[mi];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = m_bad ? S_WB : S_MUL_ACT;
      S_MUL_ACT: state_nxt = S_MUL_PAS;
      S_MUL_PAS: state_nxt = S_MUL_GN;
      S_MUL_GN:  state_nxt = S_DES;
      S_DES:     state_nxt = S_MUL_IN;
      S_MUL_IN:  state_nxt = S_MUL_OLD;
      S_MUL_OLD: state_nxt = S_ACC3;
      S_ACC3:    state_nxt = S_FIN;
      S_FIN:     state_nxt = S_WB;
      S_WB:      if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control, coefficients and filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      coef_input_r <= '0;
      coef_prev_r  <= '0;
      coef_prev2_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        last_r[i]  <= '0;
        older_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_INPUT: coef_input_r <= cfg_wdata;
          CFG_COEF_PREV:  coef_prev_r  <= cfg_wdata;
          CFG_COEF_PREV2: coef_prev2_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_FIN) begin
        last_r[mi]  <= sat32(y_round);
        older_r[mi] <= last_r[mi];
      end
      if (state_r == S_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      m_r   <= in_motor_index;
      act_r <= in_weighted_activation;
      pos_r <= in_motor_position;
      y_r   <= '0;
    end
    case (state_r)
      S_MUL_PAS: begin
        // active product back in Q16.16, clamped: beyond 32 bits the torque saturates anyway
        r_r <= sat32(ACC_W'(r_round));
      end
      S_MUL_GN:  tpas_r <= tpas_round[DATA_W:0];
      S_DES:     tdes_r <= sat32(ACC_W'(t_diff));
      S_MUL_IN:  acc_r  <= ACC_W'(prod_r);
      S_MUL_OLD: acc_r  <= acc_r + ACC_W'(prod_r);
      S_ACC3:    acc_r  <= acc_r + ACC_W'(prod_r);
      S_FIN:     y_r    <= sat32(y_round);
      default: ;
    endcase
    if (state_r == S_WB && out_free) begin
      out_channel_r <= m_r;
      out_ref_r     <= y_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_ref_position = out_ref_r;

endmodule

// ----- tb/sv/emg_torque_filter_checker.sv -----
`timescale 1ns / 100ps

// watches both channels and the register port, predicts every reference
// position and compares it with what the block returns
module emg_torque_filter_checker
  import emgtq_pkg::*;
#(
  parameter int NUM_MOTORS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_motor_index,
  input  word_t      in_weighted_activation,
  input  word_t      in_motor_position,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_channel,
  input  word_t      out_ref_position,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  word_t      cfg_wdata,
  output int         failures,
  output int         pending_results
);

  localparam longint WORD_TOP    = 64'sd2147483647;
  localparam longint WORD_BOTTOM = -64'sd2147483648;
  localparam longint HALF_Q30    = 64'sd1 <<< 29;
  localparam longint HALF_Q16    = 64'sd1 <<< 15;

  typedef struct packed {
    logic [3:0] channel;
    word_t      ref_position;
  } position_result_t;

  word_t coef_input;
  word_t coef_prev;
  word_t coef_prev2;
  word_t last_out  [NUM_MOTORS];
  word_t older_out [NUM_MOTORS];

  position_result_t expected_positions [$];
  position_result_t want;
  int               n_fail;

  function automatic word_t clamp_word(input acc_t v);
    acc_t top_lim;
    acc_t bottom_lim;
    top_lim    = ACC_W'(WORD_TOP);
    bottom_lim = ACC_W'(WORD_BOTTOM);
    if (v > top_lim) begin
      return 32'sh7fffffff;
    end else if (v < bottom_lim) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // per-motor norms and gains: first three wrist channels are unscaled
  function automatic void motor_constants(input int m, output longint flex, output longint ext,
                                          output longint act_gain, output longint pas_gain);
    if (m < 3) begin
      flex = 1073741824;
      ext = 1073741824;
      act_gain = 0;
      pas_gain = 0;
    end else if (m == 3) begin
      flex = 2014147109;
      ext = 1363654844;
      act_gain = 1500;
      pas_gain = 0;
    end else begin
      flex = 932553260;
      ext = 773923760;
      act_gain = 1500;
      pas_gain = 32768;
    end
  endfunction

  function automatic word_t next_position(input int m, input word_t act, input word_t pos);
    longint flex, ext, act_gain, pas_gain;
    longint a, p, torque_act, torque_pas;
    acc_t   demand, sum, term;
    word_t  demand_sat;
    motor_constants(m, flex, ext, act_gain, pas_gain);
    a = longint'(act);
    p = longint'(pos);
    torque_act = ((a * ((act > 0) ? flex : ext) + HALF_Q30) >>> 30) * act_gain;
    torque_pas = (pas_gain * p + HALF_Q16) >>> 16;
    demand = ACC_W'(torque_act - torque_pas);
    demand_sat = clamp_word(demand);
    // exact sum of the three Q2.30 x Q16.16 products, then round half up
    a = longint'(coef_input);
    p = longint'(demand_sat);
    sum = ACC_W'(a * p);
    a = longint'(coef_prev);
    p = longint'(last_out[m]);
    term = ACC_W'(a * p);
    sum = sum + term;
    a = longint'(coef_prev2);
    p = longint'(older_out[m]);
    term = ACC_W'(a * p);
    sum = sum + term + ACC_W'(HALF_Q30);
    return clamp_word(sum >>> 30);
  endfunction

  initial begin
    n_fail = 0;
    failures = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      coef_input = '0;
      coef_prev = '0;
      coef_prev2 = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        last_out[i] = '0;
        older_out[i] = '0;
      end
      expected_positions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_INPUT: coef_input = cfg_wdata;
          CFG_COEF_PREV:  coef_prev = cfg_wdata;
          CFG_COEF_PREV2: coef_prev2 = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want.channel = in_motor_index;
        if (in_motor_index < NUM_MOTORS) begin
          want.ref_position = next_position(int'(in_motor_index), in_weighted_activation,
                                            in_motor_position);
          older_out[in_motor_index] = last_out[in_motor_index];
          last_out[in_motor_index] = want.ref_position;
        end else begin
          want.ref_position = '0;
        end
        expected_positions.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got channel %0d position %0d",
                   $time, out_channel, $signed(out_ref_position));
          n_fail++;
        end else begin
          want = expected_positions.pop_front();
          if (out_channel !== want.channel) begin
            $display("%0t: channel mismatch, expected %0d, got %0d",
                     $time, want.channel, out_channel);
            n_fail++;
          end
          if (out_ref_position !== want.ref_position) begin
            $display("%0t: ref_position mismatch on channel %0d, expected %0d, got %0d",
                     $time, want.channel, $signed(want.ref_position),
                     $signed(out_ref_position));
            n_fail++;
          end
        end
      end
    end
    failures <= n_fail;
    pending_results <= expected_positions.size();
  end

endmodule

// ----- tb/sv/emg_torque_second_order_filter_top_test.sv -----
`timescale 1ns / 100ps

// stimulus and verdict; all prediction and comparison sits in the checker
module emg_torque_second_order_filter_top_test;
  import emgtq_pkg::*;

  localparam int NUM_MOTORS = 14;

  // no register behind this index, writes to it must be ignored
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam word_t WORD_MAX  = 32'sh7fffffff;
  localparam word_t WORD_MIN  = 32'sh80000000;
  localparam word_t ONE_Q16   = 32'sd65536;
  localparam word_t UNITY_Q30 = 32'sd1073741824;

  // critically damped low-pass with Wn*T = 0.1, dc gain close to one
  localparam word_t LP_INPUT = 32'sd8873908;
  localparam word_t LP_PREV  = 32'sd1952259680;
  localparam word_t LP_PREV2 = -32'sd887390764;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int QUIET_ITEMS    = 30;
  localparam int BURST_ITEMS    = 40;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE_CYCLES  = 16;
  localparam int STALL_LIMIT    = 3000;

  typedef enum int {
    PROFILE_LOWPASS,
    PROFILE_UNITY,
    PROFILE_TOP,
    PROFILE_BOTTOM,
    PROFILE_WILD,
    PROFILE_MILD,
    PROFILE_KINDS
  } coef_profile_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_motor_index;
  word_t      in_weighted_activation;
  word_t      in_motor_position;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_channel;
  word_t      out_ref_position;
  logic       cfg_we;
  logic [1:0] cfg_index;
  word_t      cfg_wdata;

  int failures;
  int pending_results;

  // run statistics for the closing summary
  int samples_sent;
  int stray_indexes;
  int results_taken;
  int settings_loaded;

  // the stimulus bumps this to ask the receiver for one long hold-off
  int holds_wanted;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  emg_torque_second_order_filter_top #(
    .NUM_MOTORS(NUM_MOTORS)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_motor_index         (in_motor_index),
    .in_weighted_activation (in_weighted_activation),
    .in_motor_position      (in_motor_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_channel            (out_channel),
    .out_ref_position       (out_ref_position),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  emg_torque_filter_checker #(
    .NUM_MOTORS(NUM_MOTORS)
  ) checker_inst (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_motor_index         (in_motor_index),
    .in_weighted_activation (in_weighted_activation),
    .in_motor_position      (in_motor_position),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_channel            (out_channel),
    .out_ref_position       (out_ref_position),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .failures               (failures),
    .pending_results        (pending_results)
  );

  // offer one sample after an optional gap, hold it until the block takes it
  task automatic send_sample(input logic [3:0] m, input word_t act, input word_t pos,
                             input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_motor_index = m;
    in_weighted_activation = act;
    in_motor_position = pos;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (m >= NUM_MOTORS) begin
      stray_indexes++;
    end
  endtask

  // let every outstanding transaction come back so the registers can change
  task automatic drain();
    @(negedge clk) in_valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefficients(input word_t c_in, input word_t c_prev, input word_t c_prev2,
                                   input bit poke_spare);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_COEF_INPUT;
    cfg_wdata = c_in;
    @(negedge clk);
    cfg_index = CFG_COEF_PREV;
    cfg_wdata = c_prev;
    @(negedge clk);
    cfg_index = CFG_COEF_PREV2;
    cfg_wdata = c_prev2;
    if (poke_spare) begin
      @(negedge clk);
      cfg_index = CFG_SPARE;
      cfg_wdata = $urandom();
    end
    @(negedge clk);
    cfg_we = 1'b0;
    settings_loaded++;
  endtask

  // full-range words as the largest share, with small values, extremes and zero
  function automatic word_t pick_value();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      7:       return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      8:       return '0;
      9:       return $urandom_range(0, 64) - 32;
      default: return $urandom();
    endcase
  endfunction

  // about one sample in twenty goes to an index past the last motor
  function automatic logic [3:0] pick_motor();
    if ($urandom_range(0, 19) == 0) begin
      return 4'($urandom_range(NUM_MOTORS, 15));
    end
    return 4'($urandom_range(0, NUM_MOTORS - 1));
  endfunction

  // runs of samples on one motor so its filter history builds up
  task automatic random_phase(input int count);
    int         k;
    int         run;
    logic [3:0] m;
    k = 0;
    while (k < count) begin
      m = pick_motor();
      run = $urandom_range(1, 8);
      repeat (run) begin
        send_sample(m, pick_value(), pick_value(), k < QUIET_ITEMS);
        k++;
      end
    end
  endtask

  // receiver: a random hold-off before each result, a long one on request,
  // and a stretch without hold-offs every so often
  initial begin : receiver
    int hold;
    int holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_wanted) begin
        hold = LONG_HOLD;
        holds_done++;
      end else if ((results_taken % 150) < 25) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // give up once neither channel has moved for far too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    coef_profile_t profile;
    word_t         c0, c1, c2;
    samples_sent = 0;
    stray_indexes = 0;
    results_taken = 0;
    settings_loaded = 0;
    holds_wanted = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_motor_index = '0;
    in_weighted_activation = '0;
    in_motor_position = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_COEF_INPUT;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // coefficients come out of reset at zero, so every position is zero
    send_sample(4'd0, WORD_MAX, WORD_MAX, 1'b0);
    send_sample(4'd13, WORD_MIN, WORD_MIN, 1'b0);
    send_sample(4'd15, 32'sd1, 32'sd1, 1'b0);
    send_sample(4'd14, WORD_MAX, WORD_MIN, 1'b0);
    drain();

    // unity weight on the demand: the output shows the torque term itself
    load_coefficients(UNITY_Q30, '0, '0, 1'b1);
    send_sample(4'd3, ONE_Q16, '0, 1'b0);           // flexion norm
    send_sample(4'd3, -ONE_Q16, '0, 1'b0);          // extension norm
    send_sample(4'd3, '0, WORD_MAX, 1'b0);          // zero activation, no passive gain
    send_sample(4'd4, '0, ONE_Q16, 1'b0);           // passive term only
    send_sample(4'd5, '0, WORD_MAX, 1'b0);
    send_sample(4'd5, '0, WORD_MIN, 1'b0);
    send_sample(4'd6, WORD_MAX, '0, 1'b0);          // demand clamps high
    send_sample(4'd7, WORD_MIN, '0, 1'b0);          // demand clamps low
    send_sample(4'd0, WORD_MAX, WORD_MIN, 1'b0);    // unscaled channel, zero gains
    send_sample(4'd2, 32'sd1, -32'sd1, 1'b0);
    send_sample(4'd13, 32'sd1, 32'sd1, 1'b0);       // rounding of tiny products
    send_sample(4'd12, -32'sd1, -32'sd1, 1'b0);
    send_sample(4'd11, '0, 32'sd1, 1'b0);           // half rounds up
    send_sample(4'd14, ONE_Q16, ONE_Q16, 1'b0);     // past the last motor
    send_sample(4'd15, WORD_MIN, WORD_MAX, 1'b0);
    drain();

    // largest and smallest weights drive the output into saturation
    load_coefficients(WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
    repeat (3) send_sample(4'd9, WORD_MAX, WORD_MIN, 1'b0);
    drain();
    load_coefficients(WORD_MIN, WORD_MIN, WORD_MIN, 1'b1);
    repeat (3) send_sample(4'd9, WORD_MAX, WORD_MIN, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      profile = coef_profile_t'(p % PROFILE_KINDS);
      case (profile)
        PROFILE_LOWPASS: begin
          c0 = LP_INPUT;
          c1 = LP_PREV;
          c2 = LP_PREV2;
        end
        PROFILE_UNITY: begin
          c0 = UNITY_Q30;
          c1 = '0;
          c2 = '0;
        end
        PROFILE_TOP: begin
          c0 = WORD_MAX;
          c1 = WORD_MAX;
          c2 = WORD_MAX;
        end
        PROFILE_BOTTOM: begin
          c0 = WORD_MIN;
          c1 = WORD_MIN;
          c2 = WORD_MIN;
        end
        PROFILE_WILD: begin
          c0 = $urandom();
          c1 = $urandom();
          c2 = $urandom();
        end
        default: begin
          // moderate weights within a quarter of the range
          c0 = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          c1 = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          c2 = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end
      endcase
      load_coefficients(c0, c1, c2, p[0]);
      if (p == 0) begin
        // receiver sits on a result while samples keep coming back to back
        holds_wanted++;
        repeat (BURST_ITEMS) send_sample(pick_motor(), pick_value(), pick_value(), 1'b1);
      end
      random_phase(ITEMS_PER_PHASE);
      drain();
    end

    $display("covered %0d motor samples (%0d past the last motor) and %0d results",
             samples_sent, stray_indexes, results_taken);
    $display("over %0d coefficient settings, with one receiver hold-off of %0d cycles",
             settings_loaded, LONG_HOLD);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
